[hdl/nvsplit_pkg.sv]
// ----------------------------------------------------------------------------
// nvsplit_pkg
// Shared types, constants and codes of the NVMe I/O command splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package nvsplit_pkg;

    // Request limits
    localparam int MAX_PIECES = 64;
    localparam int CNT_W      = $clog2(MAX_PIECES + 2);

    // Flag and tag layout
    localparam logic [31:0] LOW_FLAG_MASK = 32'h0000_FFFF;
    localparam int          HALF_SHIFT    = 16;

    // NVMe opcodes
    localparam logic [7:0] OPC_WRITE = 8'h01;
    localparam logic [7:0] OPC_READ  = 8'h02;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register widths
    localparam int MAXT_W   = 17;
    localparam int STRIPE_W = 21;
    localparam int BLKB_W   = 17;
    localparam int METAB_W  = 13;
    localparam int STRIDE_W = 18;

    // Register reset values
    localparam logic [MAXT_W-1:0]   RST_MAX_XFER   = 17'd256;
    localparam logic [STRIPE_W-1:0] RST_STRIPE     = 21'd0;
    localparam logic [BLKB_W-1:0]   RST_BLOCK_B    = 17'd512;
    localparam logic [METAB_W-1:0]  RST_META_B     = 13'd0;
    localparam logic [1:0]          RST_PROT_TYPE  = 2'd0;
    localparam logic                RST_EXT_FMT    = 1'b0;
    localparam logic [31:0]         RST_NSID       = 32'd1;
    localparam logic [4:0]          RST_PRACT_BIT  = 5'd29;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_XFER  = 3'd0,
        CFG_STRIPE    = 3'd1,
        CFG_BLOCK_B   = 3'd2,
        CFG_META_B    = 3'd3,
        CFG_PROT_TYPE = 3'd4,
        CFG_EXT_FMT   = 3'd5,
        CFG_NSID      = 3'd6,
        CFG_PRACT_BIT = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FLAGS  = 2'd1,
        ST_ZERO_COUNT = 2'd2,
        ST_TOO_MANY   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_CHECK = 3'd1,
        S_COUNT = 3'd2,
        S_STEP  = 3'd3,
        S_LOAD  = 3'd4,
        S_ERR   = 3'd5
    } t_state;

    typedef struct packed {
        logic [MAXT_W-1:0]   max_xfer;
        logic [STRIPE_W-1:0] stripe;
        logic [BLKB_W-1:0]   block_b;
        logic [METAB_W-1:0]  meta_b;
        logic [1:0]          prot_type;
        logic                ext_fmt;
        logic [31:0]         nsid;
        logic [4:0]          pract_bit;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic    cap;
        logic    init;
        logic    cnt;
        logic    step;
        logic    load_piece;
        logic    load_err;
        t_status err_code;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bad_flags;
        logic zero_count;
        logic skip_count;
        logic count_over;
        logic count_done;
        logic piece_last;
    } t_dp_stat;

endpackage

`default_nettype wire

[hdl/nvsplit_req_if.sv]
// ----------------------------------------------------------------------------
// nvsplit_req_if
// Request channel: one read or write request per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nvsplit_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] start_block;
    logic [31:0] block_count;
    logic [31:0] rw_flags;
    logic [15:0] tag_mask;
    logic [15:0] app_tag;

    modport source (
        output valid, action, start_block, block_count, rw_flags, tag_mask, app_tag,
        input  ready
    );
    modport sink (
        input  valid, action, start_block, block_count, rw_flags, tag_mask, app_tag,
        output ready
    );
endinterface

`default_nettype wire

[hdl/nvsplit_rsp_if.sv]
// ----------------------------------------------------------------------------
// nvsplit_rsp_if
// Result channel: one command word set or error per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nvsplit_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        last;
    logic [7:0]  opcode;
    logic [31:0] nsid;
    logic [63:0] piece_lba;
    logic [31:0] dword12;
    logic [31:0] ref_tag;
    logic [31:0] dword15;
    logic [31:0] data_offset;
    logic [31:0] meta_offset;

    modport source (
        output valid, status, last, opcode, nsid, piece_lba, dword12, ref_tag,
               dword15, data_offset, meta_offset,
        input  ready
    );
    modport sink (
        input  valid, status, last, opcode, nsid, piece_lba, dword12, ref_tag,
               dword15, data_offset, meta_offset,
        output ready
    );
endinterface

`default_nettype wire

[hdl/nvsplit_cfg_regs.sv]
// ----------------------------------------------------------------------------
// nvsplit_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module nvsplit_cfg_regs
    import nvsplit_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Load defaults on reset, update one register per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_xfer  <= RST_MAX_XFER;
            r_cfg.stripe    <= RST_STRIPE;
            r_cfg.block_b   <= RST_BLOCK_B;
            r_cfg.meta_b    <= RST_META_B;
            r_cfg.prot_type <= RST_PROT_TYPE;
            r_cfg.ext_fmt   <= RST_EXT_FMT;
            r_cfg.nsid      <= RST_NSID;
            r_cfg.pract_bit <= RST_PRACT_BIT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_XFER:  r_cfg.max_xfer  <= i_cfg_data[MAXT_W-1:0];
                CFG_STRIPE:    r_cfg.stripe    <= i_cfg_data[STRIPE_W-1:0];
                CFG_BLOCK_B:   r_cfg.block_b   <= i_cfg_data[BLKB_W-1:0];
                CFG_META_B:    r_cfg.meta_b    <= i_cfg_data[METAB_W-1:0];
                CFG_PROT_TYPE: r_cfg.prot_type <= i_cfg_data[1:0];
                CFG_EXT_FMT:   r_cfg.ext_fmt   <= i_cfg_data[0];
                CFG_NSID:      r_cfg.nsid      <= i_cfg_data[31:0];
                CFG_PRACT_BIT: r_cfg.pract_bit <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hdl/nvsplit_ctrl.sv]
// ----------------------------------------------------------------------------
// nvsplit_ctrl
// Sequencer: accept, check, optional piece count pass, then piece emission.
// ----------------------------------------------------------------------------
`default_nettype none

module nvsplit_ctrl
    import nvsplit_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  logic     i_rsp_ready,
    output logic     o_rsp_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state  r_state, n_state;
    t_status r_err, n_err;
    logic    r_ovalid, n_ovalid;
    logic    out_free;

    // State, error code and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_err    <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        n_err            = r_err;
        o_cmd            = '0;
        o_cmd.err_code   = r_err;
        o_req_ready      = 1'b0;
        out_free         = !r_ovalid || i_rsp_ready;
        n_ovalid         = r_ovalid && !i_rsp_ready;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.bad_flags) begin
                    n_err   = ST_BAD_FLAGS;
                    n_state = S_ERR;
                end else if (i_stat.zero_count) begin
                    n_err   = ST_ZERO_COUNT;
                    n_state = S_ERR;
                end else begin
                    o_cmd.init = 1'b1;
                    n_state    = i_stat.skip_count ? S_STEP : S_COUNT;
                end
            end
            S_COUNT: begin
                // walk the pieces once, bail out past the limit
                o_cmd.cnt = 1'b1;
                if (i_stat.count_over) begin
                    n_err   = ST_TOO_MANY;
                    n_state = S_ERR;
                end else if (i_stat.count_done) begin
                    o_cmd.init = 1'b1;
                    n_state    = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    o_cmd.load_piece = 1'b1;
                    n_ovalid         = 1'b1;
                    if (i_stat.piece_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    o_cmd.load_err = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp_valid = r_ovalid;

endmodule

`default_nettype wire

[hdl/nvsplit_dp.sv]
// ----------------------------------------------------------------------------
// nvsplit_dp
// Datapath: held request, piece cursor, piece length unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nvsplit_dp
    import nvsplit_pkg::*;
(
    input  logic        i_clk,
    input  t_cfg        i_cfg,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_action,
    input  logic [63:0] i_start_block,
    input  logic [31:0] i_block_count,
    input  logic [31:0] i_rw_flags,
    input  logic [15:0] i_tag_mask,
    input  logic [15:0] i_app_tag,
    output logic [1:0]  o_status,
    output logic        o_last,
    output logic [7:0]  o_opcode,
    output logic [31:0] o_nsid,
    output logic [63:0] o_piece_lba,
    output logic [31:0] o_dword12,
    output logic [31:0] o_ref_tag,
    output logic [31:0] o_dword15,
    output logic [31:0] o_data_offset,
    output logic [31:0] o_meta_offset
);

    // Held request
    logic        r_action;
    logic [63:0] r_start;
    logic [31:0] r_count;
    logic [31:0] r_flags;
    logic [15:0] r_tmask;
    logic [15:0] r_tag;

    // Per-request settings
    logic                r_cross;
    logic [STRIDE_W-1:0] r_stride;

    // Cursor
    logic [63:0]      r_lba;
    logic [31:0]      r_rem;
    logic [31:0]      r_segl;
    logic [CNT_W-1:0] r_n;

    // Staged piece
    logic [MAXT_W-1:0] r_p;
    logic [63:0]       r_plba;
    logic              r_plast;

    // Offsets of the staged piece
    logic [31:0] r_doff;
    logic [31:0] r_moff;

    // Result register
    logic [1:0]  r_o_status;
    logic        r_o_last;
    logic [7:0]  r_o_opcode;
    logic [31:0] r_o_nsid;
    logic [63:0] r_o_lba;
    logic [31:0] r_o_dw12;
    logic [31:0] r_o_ref;
    logic [31:0] r_o_dw15;
    logic [31:0] r_o_doff;
    logic [31:0] r_o_moff;

    logic [MAXT_W-1:0]          maxt;
    logic [STRIPE_W-1:0]        smask;
    logic [STRIPE_W-1:0]        segsz;
    logic [32:0]                cross_sum;
    logic                       cross_c;
    logic [STRIDE_W-1:0]        stride_c;
    logic [31:0]                seg_start;
    logic [31:0]                seg_cur;
    logic [MAXT_W-1:0]          p;
    logic [31:0]                rem_next;
    logic [31:0]                segl_next;
    logic [63:0]                lba_next;
    logic [CNT_W-1:0]           n_next;
    logic [MAXT_W+STRIDE_W-1:0] dprod;
    logic [MAXT_W+METAB_W-1:0]  mprod;
    logic [MAXT_W+CNT_W-1:0]    max_total;

    // Piece length unit: one piece per cycle, unless the result channel holds the flow
    always_comb begin
        maxt      = (i_cfg.max_xfer == '0) ? MAXT_W'(1) : i_cfg.max_xfer;
        smask     = i_cfg.stripe - STRIPE_W'(1);
        segsz     = i_cfg.stripe - (r_lba[STRIPE_W-1:0] & smask);
        seg_start = (r_cross && (32'(segsz) < r_rem)) ? 32'(segsz) : r_rem;
        seg_cur   = (r_segl == '0) ? seg_start : r_segl;
        p         = (seg_cur < 32'(maxt)) ? seg_cur[MAXT_W-1:0] : maxt;
        rem_next  = r_rem - 32'(p);
        segl_next = seg_cur - 32'(p);
        lba_next  = r_lba + 64'(p);
        n_next    = r_n + CNT_W'(1);
    end

    // Request checks: flags, zero count, stripe crossing, stride, and whether counting is needed
    always_comb begin
        cross_sum = 33'(r_start[STRIPE_W-1:0] & smask) + 33'(r_count);
        cross_c   = (i_cfg.stripe != '0) && (cross_sum > 33'(i_cfg.stripe));
        stride_c  = STRIDE_W'(i_cfg.block_b);
        if ((i_cfg.prot_type != 2'd0) && i_cfg.ext_fmt && !r_flags[i_cfg.pract_bit]) begin
            stride_c = STRIDE_W'(i_cfg.block_b) + STRIDE_W'(i_cfg.meta_b);
        end
        max_total = (MAXT_W+CNT_W)'(maxt) * (MAXT_W+CNT_W)'(MAX_PIECES);
        o_stat.bad_flags  = (r_flags & LOW_FLAG_MASK) != '0;
        o_stat.zero_count = (r_count == '0);
        o_stat.skip_count = (r_count <= 32'(MAX_PIECES)) ||
                            (!cross_c && ({(MAXT_W+CNT_W)'(0), r_count} <=
                                          {32'(0), max_total}));
        o_stat.count_over = (n_next > CNT_W'(MAX_PIECES));
        o_stat.count_done = (rem_next == '0);
        o_stat.piece_last = r_plast;
    end

    // Offset advance for the staged piece
    assign dprod = (MAXT_W+STRIDE_W)'(r_p) * (MAXT_W+STRIDE_W)'(r_stride);
    assign mprod = (MAXT_W+METAB_W)'(r_p) * (MAXT_W+METAB_W)'(i_cfg.meta_b);

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_action <= i_action;
            r_start  <= i_start_block;
            r_count  <= i_block_count;
            r_flags  <= i_rw_flags;
            r_tmask  <= i_tag_mask;
            r_tag    <= i_app_tag;
        end
    end

    // Rewind or advance the cursor
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_lba    <= r_start;
            r_rem    <= r_count;
            r_segl   <= '0;
            r_n      <= '0;
            r_cross  <= cross_c;
            r_stride <= stride_c;
        end else begin
            if (i_cmd.cnt || i_cmd.step) begin
                r_lba  <= lba_next;
                r_rem  <= rem_next;
                r_segl <= segl_next;
            end
            if (i_cmd.cnt) begin
                r_n <= n_next;
            end
        end
    end

    // Stage the next piece
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_p     <= p;
            r_plba  <= r_lba;
            r_plast <= (rem_next == '0);
        end
    end

    // Hold offsets of the staged piece
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_doff <= '0;
            r_moff <= '0;
        end else if (i_cmd.load_piece) begin
            r_doff <= r_doff + dprod[31:0];
            r_moff <= r_moff + 32'(mprod);
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_piece) begin
            r_o_status <= ST_OK;
            r_o_last   <= r_plast;
            r_o_opcode <= r_action ? OPC_WRITE : OPC_READ;
            r_o_nsid   <= i_cfg.nsid;
            r_o_lba    <= r_plba;
            r_o_dw12   <= (32'(r_p) - 32'd1) | r_flags;
            r_o_ref    <= ((i_cfg.prot_type == 2'd1) || (i_cfg.prot_type == 2'd2)) ?
                          r_plba[31:0] : 32'd0;
            r_o_dw15   <= (32'(r_tmask) << HALF_SHIFT) | 32'(r_tag);
            r_o_doff   <= r_doff;
            r_o_moff   <= r_moff;
        end else if (i_cmd.load_err) begin
            r_o_status <= i_cmd.err_code;
            r_o_last   <= 1'b1;
            r_o_opcode <= '0;
            r_o_nsid   <= '0;
            r_o_lba    <= '0;
            r_o_dw12   <= '0;
            r_o_ref    <= '0;
            r_o_dw15   <= '0;
            r_o_doff   <= '0;
            r_o_moff   <= '0;
        end
    end

    assign o_status      = r_o_status;
    assign o_last        = r_o_last;
    assign o_opcode      = r_o_opcode;
    assign o_nsid        = r_o_nsid;
    assign o_piece_lba   = r_o_lba;
    assign o_dword12     = r_o_dw12;
    assign o_ref_tag     = r_o_ref;
    assign o_dword15     = r_o_dw15;
    assign o_data_offset = r_o_doff;
    assign o_meta_offset = r_o_moff;

endmodule

`default_nettype wire

[hdl/nvme_io_command_splitter_unit.sv]
// ----------------------------------------------------------------------------
// nvme_io_command_splitter_unit
// Cuts one NVMe read/write request into command word sets at stripe
// boundaries and at the maximum transfer size.
// ----------------------------------------------------------------------------
// One request is taken at a time. A request of n pieces is accepted,
// checked and has its first piece staged, then gives n output beats,
// one piece per cycle while there is no back pressure. When a request
// could exceed the 64-piece limit (more than 64 blocks and either
// crossing a stripe or longer than 64 maximum transfers), a counting
// pass runs first through the same piece length unit. Error results
// (flags in the low half, zero count, too many pieces) come out as one
// beat with last set, after the check or the counting pass. The result
// register lets the next request be accepted while the final beat still
// waits to be taken. Configuration writes are taken at any time and
// must only be done while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nvme_io_command_splitter_unit
    import nvsplit_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nvsplit_req_if.sink           i_req,
    nvsplit_rsp_if.source         o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    nvsplit_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    nvsplit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    nvsplit_dp u_dp (
        .i_clk         (i_clk),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_req.action),
        .i_start_block (i_req.start_block),
        .i_block_count (i_req.block_count),
        .i_rw_flags    (i_req.rw_flags),
        .i_tag_mask    (i_req.tag_mask),
        .i_app_tag     (i_req.app_tag),
        .o_status      (o_rsp.status),
        .o_last        (o_rsp.last),
        .o_opcode      (o_rsp.opcode),
        .o_nsid        (o_rsp.nsid),
        .o_piece_lba   (o_rsp.piece_lba),
        .o_dword12     (o_rsp.dword12),
        .o_ref_tag     (o_rsp.ref_tag),
        .o_dword15     (o_rsp.dword15),
        .o_data_offset (o_rsp.data_offset),
        .o_meta_offset (o_rsp.meta_offset)
    );

endmodule

`default_nettype wire

[hdl/nvsplit_checker.sv]
// ----------------------------------------------------------------------------
// nvsplit_checker
// Port-level assertions of the command splitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nvsplit_checker
    import nvsplit_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [1:0]  i_rsp_status,
    input  logic        i_rsp_last,
    input  logic [7:0]  i_rsp_opcode,
    input  logic [63:0] i_rsp_piece_lba,
    input  logic [31:0] i_rsp_data_offset
);

    // Hold a stalled result beat
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_piece_lba) && $stable(i_rsp_last))
        else $error("stalled result beat changed");

    // An error beat is the final beat, with zeroed opcode and data offset
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK) |->
            i_rsp_last && (i_rsp_opcode == 8'h00) && (i_rsp_data_offset == 32'd0))
        else $error("error beat not final or not cleared");

    // A good beat carries a read or write opcode
    a_ok_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_OK) |->
            (i_rsp_opcode == OPC_READ) || (i_rsp_opcode == OPC_WRITE))
        else $error("good beat with bad opcode");

    // Drop ready right after a request is taken
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken while busy");

endmodule

bind nvme_io_command_splitter_unit nvsplit_checker u_nvsplit_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_last        (o_rsp.last),
    .i_rsp_opcode      (o_rsp.opcode),
    .i_rsp_piece_lba   (o_rsp.piece_lba),
    .i_rsp_data_offset (o_rsp.data_offset)
);

`default_nettype wire
